/* hw/rtl/tfs_pkg.sv */
// Package for the TLV frame serializer: item structs, burst descriptor,
// mode, status and register index codes. No dependencies.
`default_nettype none

package tfs_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int TL_BYTES     = 2;
    localparam int BURST_MAX    = 12;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_REC   = 2'd1;
    localparam logic [1:0] MODE_VALUE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ROOM = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_NO_FRM  = 2'd3;

    localparam logic [1:0] REG_MAGIC    = 2'd0;
    localparam logic [1:0] REG_VERSION  = 2'd1;
    localparam logic [1:0] REG_CAPACITY = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] timestamp;
        logic [31:0] sequence_number;
        logic [7:0]  record_type;
        logic [7:0]  record_length;
        logic [7:0]  value_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] byte_offset;
        logic [1:0]  status;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [15:0] magic_word;
        logic [7:0]  format_version;
        logic [15:0] capacity_bytes;
    } t_cfg;

    // One item's worth of result beats, handed from decoder to emitter.
    typedef struct packed {
        logic                      emit;
        logic [3:0]                last_idx;
        logic                      hdr;
        logic [1:0]                status;
        logic [15:0]               off0;
        logic [15:0]               off1;
        logic [BURST_MAX-1:0][7:0] bytes;
    } t_burst;

endpackage

`default_nettype wire

/* hw/rtl/tfs_decode.sv */
// Frame state and per-item decode: turns one registered item into a burst
// descriptor and updates the frame state when the item is consumed. Uses tfs_pkg.
`default_nettype none

module tfs_decode import tfs_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_fire,
    output t_burst        o_burst
);

    localparam int LB = LENGTH_BITS;
    localparam int CW = ((LB > 16) ? LB : 16) + 1;

    logic          r_frame_open,   n_frame_open;
    logic [LB-1:0] r_frame_length, n_frame_length;
    logic [7:0]    r_left,         n_left;
    logic          r_dropping,     n_dropping;

    logic [CW-1:0] need;
    logic [CW-1:0] len_w0;
    logic [CW-1:0] len_w1;
    logic [LB-1:0] len_p1;

    assign need   = CW'(r_frame_length) + CW'(TL_BYTES) + CW'(i_item.record_length);
    assign len_p1 = r_frame_length + LB'(1);
    assign len_w0 = CW'(r_frame_length);
    assign len_w1 = CW'(len_p1);

    always_comb begin
        n_frame_open   = r_frame_open;
        n_frame_length = r_frame_length;
        n_left         = r_left;
        n_dropping     = r_dropping;
        o_burst        = '0;
        o_burst.off0   = len_w0[15:0];
        o_burst.off1   = len_w1[15:0];
        case (i_item.mode)
            MODE_START: begin
                o_burst.emit = 1'b1;
                if (i_cfg.capacity_bytes < 16'(HEADER_BYTES)) begin
                    o_burst.status = ST_NO_ROOM;
                end else begin
                    n_frame_open     = 1'b1;
                    n_frame_length   = LB'(HEADER_BYTES);
                    n_left           = '0;
                    n_dropping       = 1'b0;
                    o_burst.hdr      = 1'b1;
                    o_burst.last_idx = 4'(HEADER_BYTES - 1);
                    o_burst.bytes[0] = i_cfg.magic_word[15:8];
                    o_burst.bytes[1] = i_cfg.magic_word[7:0];
                    o_burst.bytes[2] = i_cfg.format_version;
                    o_burst.bytes[3] = 8'h00;
                    o_burst.bytes[4] = i_item.timestamp[31:24];
                    o_burst.bytes[5] = i_item.timestamp[23:16];
                    o_burst.bytes[6] = i_item.timestamp[15:8];
                    o_burst.bytes[7] = i_item.timestamp[7:0];
                    o_burst.bytes[8] = i_item.sequence_number[31:24];
                    o_burst.bytes[9] = i_item.sequence_number[23:16];
                    o_burst.bytes[10] = i_item.sequence_number[15:8];
                    o_burst.bytes[11] = i_item.sequence_number[7:0];
                end
            end
            MODE_REC: begin
                o_burst.emit = 1'b1;
                if (!r_frame_open) begin
                    o_burst.status = ST_NO_FRM;
                end else if (need > CW'(i_cfg.capacity_bytes)) begin
                    n_dropping     = 1'b1;
                    n_left         = i_item.record_length;
                    o_burst.status = ST_NO_ROOM;
                end else begin
                    n_dropping       = 1'b0;
                    n_left           = i_item.record_length;
                    n_frame_length   = r_frame_length + LB'(TL_BYTES);
                    o_burst.last_idx = 4'd1;
                    o_burst.bytes[0] = i_item.record_type;
                    o_burst.bytes[1] = i_item.record_length;
                end
            end
            MODE_VALUE: begin
                o_burst.emit = 1'b1;
                if (!r_frame_open || r_left == 8'd0) begin
                    o_burst.status = ST_NO_FRM;
                end else begin
                    n_left = r_left - 8'd1;
                    if (r_dropping) begin
                        o_burst.status = ST_DROPPED;
                    end else begin
                        n_frame_length   = len_p1;
                        o_burst.bytes[0] = i_item.value_byte;
                    end
                end
            end
            default: begin
                // Unused mode: consumed without any beat.
                o_burst.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open   <= 1'b0;
            r_frame_length <= '0;
            r_left         <= '0;
            r_dropping     <= 1'b0;
        end else if (i_fire) begin
            r_frame_open   <= n_frame_open;
            r_frame_length <= n_frame_length;
            r_left         <= n_left;
            r_dropping     <= n_dropping;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tfs_emitter.sv */
// Result sequencer: holds one burst descriptor and plays it out one beat
// per cycle while the output channel is ready. Uses tfs_pkg.
`default_nettype none

module tfs_emitter import tfs_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_burst i_burst,
    input  wire logic   i_load,
    output logic        o_can_load,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_out_item   o_data
);

    logic       r_valid;
    logic [3:0] r_cnt;
    t_burst     r_burst;
    logic       last;

    assign last       = (r_cnt == r_burst.last_idx);
    assign o_can_load = !r_valid || (last && i_ready);
    assign o_valid    = r_valid;

    always_comb begin
        o_data             = '0;
        o_data.status      = r_burst.status;
        o_data.last_of_run = last;
        if (r_burst.status == ST_OK) begin
            o_data.data_byte = r_burst.bytes[r_cnt];
            if (r_burst.hdr) begin
                o_data.byte_offset = 16'(r_cnt);
            end else if (r_cnt == 4'd0) begin
                o_data.byte_offset = r_burst.off0;
            end else begin
                o_data.byte_offset = r_burst.off1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_load && o_can_load) begin
            r_valid <= i_burst.emit;
            r_cnt   <= '0;
        end else if (r_valid && i_ready) begin
            if (last) begin
                r_valid <= 1'b0;
            end
            r_cnt <= r_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_burst <= i_burst;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tlv_frame_serializer.sv */
// TLV frame serializer top level: input register, configuration registers,
// decoder and result sequencer. Uses tfs_pkg, tfs_decode and tfs_emitter.
// An item passes the input register, then the sequencer. Throughput: one
// item per cycle while each gives one beat and output is ready; an opened
// frame start gives twelve beats and a stored record two, one beat per cycle
// from the sequencer. Reset (synchronous, active low) empties both stages,
// closes the frame and restores magic 0, version 0 and capacity 65535.
`default_nettype none

module tlv_frame_serializer import tfs_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic     r_item_valid;
    t_in_item r_item;
    t_cfg     r_cfg;
    t_burst   burst;
    logic     can_load;
    logic     fire;

    assign fire        = r_item_valid && can_load;
    assign o_in_ready  = !r_item_valid || can_load;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word     <= 16'h0000;
            r_cfg.format_version <= 8'h00;
            r_cfg.capacity_bytes <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAGIC:    r_cfg.magic_word     <= i_cfg_data;
                REG_VERSION:  r_cfg.format_version <= i_cfg_data[7:0];
                REG_CAPACITY: r_cfg.capacity_bytes <= i_cfg_data;
                default: begin
                    // Writes beyond the register list are ignored.
                end
            endcase
        end
    end

    tfs_decode #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .i_fire  (fire),
        .o_burst (burst)
    );

    tfs_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_burst    (burst),
        .i_load     (fire),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

endmodule

`default_nettype wire

/* verif/tlv_frame_serializer_test.sv */
// Self-checking testbench for tlv_frame_serializer: a directed table, then random frames and
// records under random back-pressure, all checked beat by beat against an in-bench predictor.
// Depends on tfs_pkg and the tlv_frame_serializer RTL only.

module tlv_frame_serializer_test;
    import tfs_pkg::*;

    localparam logic [1:0] MODE_SPARE    = 2'd3;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         STALL_LIMIT   = 1000;
    localparam int         PHASE_ITEMS   = 55;
    localparam int         NUM_ROWS      = 31;

    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_in_item   item;
        logic [1:0] sel;
        logic [15:0] wdata;
        logic [1:0] status;
    } t_dir_row;

    // Typed rows carry the single refusal beat that the item must produce.
    localparam t_dir_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_TYPED, '{MODE_VALUE, 32'h0, 32'h0, 8'h00, 8'h00, 8'h5A}, REG_MAGIC, 16'h0, ST_NO_FRM},
        '{ROW_TYPED, '{MODE_REC, 32'h0, 32'h0, 8'h11, 8'h03, 8'h00}, REG_MAGIC, 16'h0, ST_NO_FRM},
        '{ROW_ITEM, '{MODE_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF},
          REG_MAGIC, 16'h0, ST_OK},
        '{ROW_CFG, '0, REG_MAGIC, 16'hFFFF, ST_OK},
        '{ROW_CFG, '0, REG_VERSION, 16'h00FF, ST_OK},
        '{ROW_ITEM, '{MODE_START, 32'hFFFF_FFFF, 32'h0, 8'h00, 8'h00, 8'h00}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_TYPED, '{MODE_VALUE, 32'h0, 32'h0, 8'h00, 8'h00, 8'hC3}, REG_MAGIC, 16'h0, ST_NO_FRM},
        '{ROW_ITEM, '{MODE_REC, 32'h0, 32'h0, 8'hFF, 8'h00, 8'h00}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_TYPED, '{MODE_VALUE, 32'h0, 32'h0, 8'h00, 8'h00, 8'h3C}, REG_MAGIC, 16'h0, ST_NO_FRM},
        '{ROW_ITEM, '{MODE_REC, 32'h0, 32'h0, 8'h00, 8'h03, 8'h00}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_ITEM, '{MODE_VALUE, 32'h0, 32'h0, 8'h00, 8'h00, 8'hFF}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_ITEM, '{MODE_SPARE, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_ITEM, '{MODE_VALUE, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_ITEM, '{MODE_REC, 32'h0, 32'h0, 8'h5A, 8'hFF, 8'h00}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_ITEM, '{MODE_VALUE, 32'h0, 32'h0, 8'h00, 8'h00, 8'hA5}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_ITEM, '{MODE_REC, 32'h0, 32'h0, 8'h3C, 8'h01, 8'h00}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_ITEM, '{MODE_VALUE, 32'h0, 32'h0, 8'h00, 8'h00, 8'h81}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_TYPED, '{MODE_VALUE, 32'h0, 32'h0, 8'h00, 8'h00, 8'h42}, REG_MAGIC, 16'h0, ST_NO_FRM},
        '{ROW_CFG, '0, REG_CAPACITY, 16'd20, ST_OK},
        '{ROW_ITEM, '{MODE_START, 32'h0, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_TYPED, '{MODE_REC, 32'h0, 32'h0, 8'h01, 8'h07, 8'h00}, REG_MAGIC, 16'h0, ST_NO_ROOM},
        '{ROW_TYPED, '{MODE_VALUE, 32'h0, 32'h0, 8'h00, 8'h00, 8'h99}, REG_MAGIC, 16'h0, ST_DROPPED},
        '{ROW_ITEM, '{MODE_REC, 32'h0, 32'h0, 8'h02, 8'h06, 8'h00}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_CFG, '0, REG_CAPACITY, 16'd11, ST_OK},
        '{ROW_TYPED, '{MODE_START, 32'h1, 32'h2, 8'h00, 8'h00, 8'h00}, REG_MAGIC, 16'h0, ST_NO_ROOM},
        '{ROW_ITEM, '{MODE_VALUE, 32'h0, 32'h0, 8'h00, 8'h00, 8'h7E}, REG_MAGIC, 16'h0, ST_OK},
        '{ROW_CFG, '0, REG_CAPACITY, 16'd0, ST_OK},
        '{ROW_TYPED, '{MODE_REC, 32'h0, 32'h0, 8'h04, 8'h00, 8'h00}, REG_MAGIC, 16'h0, ST_NO_ROOM},
        '{ROW_TYPED, '{MODE_VALUE, 32'h0, 32'h0, 8'h00, 8'h00, 8'h18}, REG_MAGIC, 16'h0, ST_NO_FRM},
        '{ROW_CFG, '0, REG_CAPACITY, 16'd12, ST_OK},
        '{ROW_ITEM, '{MODE_START, 32'h8000_0001, 32'h7FFF_FFFE, 8'h00, 8'h00, 8'h00},
          REG_MAGIC, 16'h0, ST_OK}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // Side-band with each input beat: when set, the beat must be answered by one refusal.
    logic        typed_row;
    logic [1:0]  typed_status;
    logic        calm;

    // Predicted block state and register copies.
    logic        frm_open;
    logic [15:0] frm_len;
    logic [7:0]  bytes_due;
    logic        dropping;
    logic [15:0] cfg_magic;
    logic [7:0]  cfg_version;
    logic [15:0] cfg_capacity;

    t_out_item   burst_buf [BURST_MAX];
    t_out_item   pending_beats [$];

    int errors = 0;
    int n_start = 0, n_rec = 0, n_val = 0, n_spare = 0;
    int n_beats = 0, n_refused = 0, n_dropped = 0, n_cfg = 0;
    int quiet_cycles = 0;
    int stall_left = 0;

    tlv_frame_serializer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out_item stored_beat(input logic [7:0] b);
        t_out_item beat;
        beat = '{b, frm_len, ST_OK, 1'b0};
        frm_len = frm_len + 16'd1;
        return beat;
    endfunction

    function automatic t_out_item refusal_beat(input logic [1:0] st);
        return '{8'h00, 16'h0000, st, 1'b1};
    endfunction

    // Works out the beats one input item produces and advances the predicted state.
    function automatic int serialize_item(input t_in_item it);
        int n;
        int i;
        logic [95:0] hdr;
        n = 0;
        case (it.mode)
            MODE_START: begin
                if (cfg_capacity < HEADER_BYTES) begin
                    // A refused start leaves any open frame exactly as it was.
                    burst_buf[0] = refusal_beat(ST_NO_ROOM);
                    n = 1;
                end else begin
                    frm_open  = 1'b1;
                    frm_len   = '0;
                    bytes_due = '0;
                    dropping  = 1'b0;
                    hdr = {cfg_magic, cfg_version, 8'h00, it.timestamp, it.sequence_number};
                    for (i = 0; i < HEADER_BYTES; i++) begin
                        burst_buf[4'(i)] = stored_beat(hdr[95:88]);
                        hdr = hdr << 8;
                    end
                    n = HEADER_BYTES;
                end
            end
            MODE_REC: begin
                if (!frm_open) begin
                    burst_buf[0] = refusal_beat(ST_NO_FRM);
                    n = 1;
                end else if (int'(frm_len) + TL_BYTES + int'(it.record_length)
                             > int'(cfg_capacity)) begin
                    dropping  = 1'b1;
                    bytes_due = it.record_length;
                    burst_buf[0] = refusal_beat(ST_NO_ROOM);
                    n = 1;
                end else begin
                    dropping  = 1'b0;
                    bytes_due = it.record_length;
                    burst_buf[0] = stored_beat(it.record_type);
                    burst_buf[1] = stored_beat(it.record_length);
                    n = 2;
                end
            end
            MODE_VALUE: begin
                if (!frm_open || bytes_due == 8'd0) begin
                    burst_buf[0] = refusal_beat(ST_NO_FRM);
                end else begin
                    bytes_due = bytes_due - 8'd1;
                    burst_buf[0] = dropping ? refusal_beat(ST_DROPPED) : stored_beat(it.value_byte);
                end
                n = 1;
            end
            default: n = 0;
        endcase
        if (n > 0) begin
            burst_buf[4'(n-1)].last_of_run = 1'b1;
        end
        return n;
    endfunction

    task automatic flag_field(input string name, input logic [15:0] want, input logic [15:0] seen);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
    endtask

    always @(posedge i_clk) begin : scoreboard
        int n;
        int k;
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            frm_open     = 1'b0;
            frm_len      = '0;
            bytes_due    = '0;
            dropping     = 1'b0;
            cfg_magic    = 16'h0000;
            cfg_version  = 8'h00;
            cfg_capacity = 16'hFFFF;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                n_cfg++;
                case (i_cfg_index)
                    REG_MAGIC:    cfg_magic    = i_cfg_data;
                    REG_VERSION:  cfg_version  = i_cfg_data[7:0];
                    REG_CAPACITY: cfg_capacity = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                case (i_in_data.mode)
                    MODE_START: n_start++;
                    MODE_REC:   n_rec++;
                    MODE_VALUE: n_val++;
                    default:    n_spare++;
                endcase
                n = serialize_item(i_in_data);
                if (typed_row) begin
                    pending_beats.push_back(refusal_beat(typed_status));
                end else begin
                    for (k = 0; k < n; k++) begin
                        pending_beats.push_back(burst_buf[4'(k)]);
                    end
                end
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out_data;
                n_beats++;
                if (pending_beats.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected output beat 0x%0h", $time, got);
                end else begin
                    want = pending_beats.pop_front();
                    if (want.status == ST_NO_ROOM) n_refused++;
                    if (want.status == ST_DROPPED) n_dropped++;
                    if (got.data_byte !== want.data_byte)
                        flag_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
                    if (got.byte_offset !== want.byte_offset)
                        flag_field("byte_offset", want.byte_offset, got.byte_offset);
                    if (got.status !== want.status)
                        flag_field("status", 16'(want.status), 16'(got.status));
                    if (got.last_of_run !== want.last_of_run)
                        flag_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
                end
            end
        end
    end

    // Ends the run if no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_beats.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (stall_left == 0 && !calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 19);
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // All tasks below are entered and left at a falling edge.
    task automatic send_item(input t_in_item it, input logic typed, input logic [1:0] st);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_data    <= it;
        typed_row    <= typed;
        typed_status <= st;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
        // Spare-mode items produce nothing, so give the pipeline time to empty.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [15:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item random_item(input logic [1:0] mode);
        t_in_item it;
        it.mode            = mode;
        it.timestamp       = $urandom;
        it.sequence_number = $urandom;
        it.record_type     = 8'($urandom);
        it.record_length   = 8'($urandom);
        it.value_byte      = 8'($urandom);
        return it;
    endfunction

    // Mostly complete records with their value beats, plus frame starts, records cut
    // short and single items of any mode.
    task automatic run_random_phase(input int budget);
        int sent;
        int pick;
        int len;
        int cnt;
        int k;
        t_in_item it;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_item(random_item(MODE_START), 1'b0, ST_OK);
                sent++;
            end else if (pick < 86) begin
                it = random_item(MODE_REC);
                if (pick < 74) begin
                    len = $urandom_range(0, 10);
                    cnt = len;
                end else begin
                    len = $urandom_range(0, 255);
                    cnt = $urandom_range(0, (len < 8) ? len : 8);
                end
                it.record_length = 8'(len);
                send_item(it, 1'b0, ST_OK);
                sent++;
                for (k = 0; k < cnt; k++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_item(random_item(MODE_SPARE), 1'b0, ST_OK);
                    end
                    send_item(random_item(MODE_VALUE), 1'b0, ST_OK);
                    sent++;
                end
            end else begin
                it = random_item(2'($urandom_range(0, 3)));
                send_item(it, 1'b0, ST_OK);
                if (it.mode != MODE_SPARE) sent++;
            end
        end
    endtask

    initial begin
        int r;
        int p;
        logic [15:0] cap;
        t_dir_row row;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_MAGIC;
        i_cfg_data   = '0;
        typed_row    = 1'b0;
        typed_status = ST_OK;
        calm         = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED_ROWS[5'(r)];
            if (row.kind == ROW_CFG) begin
                write_reg(row.sel, row.wdata);
            end else begin
                send_item(row.item, row.kind == ROW_TYPED, row.status);
            end
        end

        // Each phase starts from an idle block with fresh registers; the last runs flat out.
        for (p = 0; p < 4; p++) begin
            case (p)
                0:       cap = 16'hFFFF;
                1:       cap = 16'($urandom_range(20, 80));
                2:       cap = 16'($urandom_range(0, 14));
                default: cap = 16'($urandom_range(24, 120));
            endcase
            if (p == 3) calm = 1'b1;
            write_reg(REG_MAGIC, 16'($urandom));
            write_reg(REG_VERSION, 16'($urandom_range(0, 255)));
            write_reg(REG_CAPACITY, cap);
            run_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        $display("Sent %0d frame starts, %0d records, %0d value bytes, %0d spare items; %0d regs",
                 n_start, n_rec, n_val, n_spare, n_cfg);
        $display("Checked %0d output beats, %0d refused for room, %0d dropped, %0d errors",
                 n_beats, n_refused, n_dropped, errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/tfs_pkg.sv
hw/rtl/tfs_decode.sv
hw/rtl/tfs_emitter.sv
hw/rtl/tlv_frame_serializer.sv
verif/tlv_frame_serializer_test.sv
